[src/imu_cal_pkg.sv]
package imu_cal_pkg;

  localparam int RawW     = 16;
  localparam int ScaleW   = 20;
  localparam int OffW     = 20;
  localparam int CoefW    = 16;
  localparam int OutW     = 24;
  localparam int CfgW     = 60;
  localparam int RowW     = 3 * CoefW;
  localparam int IdxW     = 3;
  localparam int NumAxes  = 3;
  localparam int NumChan  = 2 * NumAxes;
  localparam int ProdW    = RawW + ScaleW + 1;
  localparam int RotProdW = CoefW + OutW;
  localparam int SumW     = RotProdW + 2;
  localparam int CalShift = 8;
  localparam int RotShift = 14;

  typedef logic signed [RawW-1:0] raw_t;
  typedef logic signed [OutW-1:0] vec_t;

  typedef enum logic [IdxW-1:0] {
    REG_ACC_SCALE   = 3'd0,
    REG_ACC_BIAS    = 3'd1,
    REG_GYRO_SCALE  = 3'd2,
    REG_GYRO_OFFSET = 3'd3,
    REG_ROT_ROW0    = 3'd4,
    REG_ROT_ROW1    = 3'd5,
    REG_ROT_ROW2    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CfgW-1:0]   acc_scale;
    logic [CfgW-1:0]   acc_bias;
    logic [ScaleW-1:0] gyro_scale;
    logic [CfgW-1:0]   gyro_offset;
    logic [RowW-1:0]   rot_row0;
    logic [RowW-1:0]   rot_row1;
    logic [RowW-1:0]   rot_row2;
  } cfg_t;

  // per-stage load enables
  typedef struct packed {
    logic mul;
    logic sub;
  } cal_adv_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } rot_adv_t;

  localparam logic signed [SumW-1:0] SatHi = SumW'((2 ** (OutW - 1)) - 1);
  localparam logic signed [SumW-1:0] SatLo = -SatHi - SumW'(1);

  function automatic vec_t sat24(input logic signed [SumW-1:0] x);
    vec_t r;
    if (x > SatHi) r = vec_t'(SatHi);
    else if (x < SatLo) r = vec_t'(SatLo);
    else r = x[OutW-1:0];
    return r;
  endfunction

endpackage

[src/imu_cal_cfg.sv]
module imu_cal_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [imu_cal_pkg::IdxW-1:0]   cfg_index,
  input  logic [imu_cal_pkg::CfgW-1:0]   cfg_data,
  output imu_cal_pkg::cfg_t              cfg
);
  import imu_cal_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.acc_scale   <= '0;
      cfg.acc_bias    <= '0;
      cfg.gyro_scale  <= '0;
      cfg.gyro_offset <= '0;
      cfg.rot_row0    <= RowW'(64'h4000);
      cfg.rot_row1    <= RowW'(64'h4000 << CoefW);
      cfg.rot_row2    <= RowW'(64'h4000 << (2 * CoefW));
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ACC_SCALE:   cfg.acc_scale   <= cfg_data;
        REG_ACC_BIAS:    cfg.acc_bias    <= cfg_data;
        REG_GYRO_SCALE:  cfg.gyro_scale  <= cfg_data[ScaleW-1:0];
        REG_GYRO_OFFSET: cfg.gyro_offset <= cfg_data;
        REG_ROT_ROW0:    cfg.rot_row0    <= cfg_data[RowW-1:0];
        REG_ROT_ROW1:    cfg.rot_row1    <= cfg_data[RowW-1:0];
        REG_ROT_ROW2:    cfg.rot_row2    <= cfg_data[RowW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/imu_cal_scale.sv]
module imu_cal_scale (
  input  logic                  clk,
  input  imu_cal_pkg::cal_adv_t adv,
  input  imu_cal_pkg::cfg_t     cfg,
  input  imu_cal_pkg::raw_t     raw [imu_cal_pkg::NumChan],
  output imu_cal_pkg::vec_t     cal [imu_cal_pkg::NumChan]
);
  import imu_cal_pkg::*;

  for (genvar i = 0; i < NumChan; i++) begin : g_chan
    logic [ScaleW-1:0]          scale;
    logic signed [OffW-1:0]     offset;
    logic signed [ProdW-1:0]    prod;
    logic signed [ProdW-1:0]    rnd;
    logic signed [SumW-1:0]     diff;

    if (i < NumAxes) begin : g_acc
      assign scale  = cfg.acc_scale[ScaleW*i +: ScaleW];
      assign offset = cfg.acc_bias[OffW*i +: OffW];
    end else begin : g_gyro
      assign scale  = cfg.gyro_scale;
      assign offset = cfg.gyro_offset[OffW*(i-NumAxes) +: OffW];
    end

    // round half up to q8.16, then remove offset
    assign rnd  = (prod + ProdW'(1 << (CalShift - 1))) >>> CalShift;
    assign diff = SumW'(rnd) - SumW'(offset);

    always_ff @(posedge clk) begin
      if (adv.mul) prod <= raw[i] * $signed({1'b0, scale});
      if (adv.sub) cal[i] <= sat24(diff);
    end
  end

endmodule

[src/imu_cal_rot.sv]
module imu_cal_rot (
  input  logic                           clk,
  input  imu_cal_pkg::rot_adv_t          adv,
  input  logic [imu_cal_pkg::RowW-1:0]   row [imu_cal_pkg::NumAxes],
  input  imu_cal_pkg::vec_t              vin [imu_cal_pkg::NumAxes],
  output imu_cal_pkg::vec_t              vout [imu_cal_pkg::NumAxes]
);
  import imu_cal_pkg::*;

  for (genvar r = 0; r < NumAxes; r++) begin : g_row
    logic signed [RotProdW-1:0] prod [NumAxes];
    logic signed [SumW-1:0]     acc;
    logic signed [SumW-1:0]     rnd;

    for (genvar c = 0; c < NumAxes; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (adv.mul) prod[c] <= $signed(row[r][CoefW*c +: CoefW]) * vin[c];
      end
    end

    assign acc = SumW'(prod[0]) + SumW'(prod[1]) + SumW'(prod[2]);
    assign rnd = (acc + SumW'(1 << (RotShift - 1))) >>> RotShift;

    always_ff @(posedge clk) begin
      if (adv.sum) vout[r] <= sat24(rnd);
    end
  end

endmodule

[src/imu_sample_calibrate_rotate_top.sv]
// throughput: one beat per cycle while out_stall is low; the four stages hold and collapse bubbles under stall
// stages: scale multiply, round and offset, matrix products, row sum and saturate
// reset: synchronous; empties the pipeline, scales and offsets to zero, matrix to identity
// a failed read gives zero vectors with status set
module imu_sample_calibrate_rotate_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [imu_cal_pkg::IdxW-1:0]  cfg_index,
  input  logic [imu_cal_pkg::CfgW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            raw_acc_x,
  input  logic signed [15:0]            raw_acc_y,
  input  logic signed [15:0]            raw_acc_z,
  input  logic signed [15:0]            raw_gyro_x,
  input  logic signed [15:0]            raw_gyro_y,
  input  logic signed [15:0]            raw_gyro_z,
  input  logic                          read_ok,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [23:0]            acc_out_x,
  output logic signed [23:0]            acc_out_y,
  output logic signed [23:0]            acc_out_z,
  output logic signed [23:0]            rate_out_x,
  output logic signed [23:0]            rate_out_y,
  output logic signed [23:0]            rate_out_z,
  output logic                          status
);
  import imu_cal_pkg::*;

  cfg_t             cfg;
  raw_t             raw [NumChan];
  vec_t             cal [NumChan];
  vec_t             acc_v [NumAxes];
  vec_t             gyro_v [NumAxes];
  vec_t             acc_r [NumAxes];
  vec_t             gyro_r [NumAxes];
  logic [RowW-1:0]  rows [NumAxes];
  logic [3:0]       vld;
  logic [3:0]       ok;
  logic [3:0]       rdy;
  cal_adv_t         cal_adv;
  rot_adv_t         rot_adv;

  imu_cal_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage k loads when it is empty or its content moves on
  assign rdy[3]   = !vld[3] || !out_stall;
  assign rdy[2]   = !vld[2] || rdy[3];
  assign rdy[1]   = !vld[1] || rdy[2];
  assign rdy[0]   = !vld[0] || rdy[1];
  assign in_stall = !rdy[0];

  assign cal_adv = '{mul: rdy[0], sub: rdy[1]};
  assign rot_adv = '{mul: rdy[2], sum: rdy[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) ok[0] <= read_ok;
    if (rdy[1]) ok[1] <= ok[0];
    if (rdy[2]) ok[2] <= ok[1];
    if (rdy[3]) ok[3] <= ok[2];
  end

  assign raw[0] = raw_acc_x;
  assign raw[1] = raw_acc_y;
  assign raw[2] = raw_acc_z;
  assign raw[3] = raw_gyro_x;
  assign raw[4] = raw_gyro_y;
  assign raw[5] = raw_gyro_z;

  imu_cal_scale u_scale (
    .clk (clk),
    .adv (cal_adv),
    .cfg (cfg),
    .raw (raw),
    .cal (cal)
  );

  assign rows[0] = cfg.rot_row0;
  assign rows[1] = cfg.rot_row1;
  assign rows[2] = cfg.rot_row2;

  for (genvar i = 0; i < NumAxes; i++) begin : g_split
    assign acc_v[i]  = cal[i];
    assign gyro_v[i] = cal[NumAxes + i];
  end

  imu_cal_rot u_rot_acc (
    .clk  (clk),
    .adv  (rot_adv),
    .row  (rows),
    .vin  (acc_v),
    .vout (acc_r)
  );

  imu_cal_rot u_rot_gyro (
    .clk  (clk),
    .adv  (rot_adv),
    .row  (rows),
    .vin  (gyro_v),
    .vout (gyro_r)
  );

  assign out_valid  = vld[3];
  assign status     = !ok[3];
  assign acc_out_x  = ok[3] ? acc_r[0]  : '0;
  assign acc_out_y  = ok[3] ? acc_r[1]  : '0;
  assign acc_out_z  = ok[3] ? acc_r[2]  : '0;
  assign rate_out_x = ok[3] ? gyro_r[0] : '0;
  assign rate_out_y = ok[3] ? gyro_r[1] : '0;
  assign rate_out_z = ok[3] ? gyro_r[2] : '0;

endmodule

[src/imu_cal_chk.sv]
module imu_cal_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [23:0]            acc_out_x,
  input logic signed [23:0]            acc_out_y,
  input logic signed [23:0]            acc_out_z,
  input logic signed [23:0]            rate_out_x,
  input logic signed [23:0]            rate_out_y,
  input logic signed [23:0]            rate_out_z,
  input logic                          status
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // input is only held off when a result is waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending output");

  // failed read carries zero vectors
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> acc_out_x == 24'sd0 && acc_out_y == 24'sd0 &&
      acc_out_z == 24'sd0 && rate_out_x == 24'sd0 && rate_out_y == 24'sd0 &&
      rate_out_z == 24'sd0)
    else $error("failed read beat with nonzero vector");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(acc_out_x) && $stable(rate_out_z))
    else $error("stalled output beat changed");

endmodule

bind imu_sample_calibrate_rotate_top imu_cal_chk u_chk (.*);
